// ===== rtl/core/biq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad IIR package
// Payload types, microcode control word and the sequencer program.
// ----------------------------------------------------------------------------
package biq_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int MAG_W    = ACC_W - 1;
    localparam int DIV_ITERS = MAG_W / 2;
    localparam int CNT_W    = $clog2(DIV_ITERS);
    localparam int UCODE_LEN = 9;
    localparam int PC_W     = $clog2(UCODE_LEN);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic        [15:0]         sample_count;
    } biq_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       fault;
    } biq_out_t;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_B0X0,
        MS_B1X1,
        MS_B2X2,
        MS_A1Y1,
        MS_A2Y2
    } biq_msel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } biq_accop_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_INIT,
        DIV_STEP
    } biq_divop_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_DONE
    } biq_seq_t;

    typedef struct packed {
        biq_msel_t  msel;
        biq_accop_t accop;
        biq_divop_t divop;
        biq_seq_t   seq;
    } biq_ucode_t;

    typedef struct packed {
        logic init;
        logic step;
    } biq_div_ctl_t;

    function automatic biq_ucode_t biq_ucode(input logic [PC_W-1:0] pc);
        biq_ucode_t cw;
        cw = '{MS_NONE, ACC_HOLD, DIV_IDLE, SEQ_NEXT};
        unique case (pc)
            4'd0: cw = '{MS_B0X0, ACC_HOLD, DIV_IDLE, SEQ_NEXT};
            4'd1: cw = '{MS_B1X1, ACC_LOAD, DIV_IDLE, SEQ_NEXT};
            4'd2: cw = '{MS_B2X2, ACC_ADD,  DIV_IDLE, SEQ_NEXT};
            4'd3: cw = '{MS_A1Y1, ACC_ADD,  DIV_IDLE, SEQ_NEXT};
            4'd4: cw = '{MS_A2Y2, ACC_SUB,  DIV_IDLE, SEQ_NEXT};
            4'd5: cw = '{MS_NONE, ACC_SUB,  DIV_IDLE, SEQ_NEXT};
            4'd6: cw = '{MS_NONE, ACC_HOLD, DIV_INIT, SEQ_NEXT};
            4'd7: cw = '{MS_NONE, ACC_HOLD, DIV_STEP, SEQ_LOOP};
            4'd8: cw = '{MS_NONE, ACC_HOLD, DIV_IDLE, SEQ_DONE};
            default: cw = '{MS_NONE, ACC_HOLD, DIV_IDLE, SEQ_DONE};
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/core/biquad_iir_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad IIR filter
// Direct form I second-order section with a microcoded multiply-accumulate
// and a divide by a0, saturating to 16 bits.
// ----------------------------------------------------------------------------
// One sample is accepted when the sequencer is idle and then goes through
// five multiply-accumulate steps on one shared 16x16 multiplier, a radix-4
// restoring divide by a0 that runs 17 iterations of the microcode loop, and
// a finish step that waits until the output register is free. No new sample
// is taken until the last one has finished; a finished result waits in the
// output register while the next sample is taken. Coefficients are signed
// Q2.14 and are written through cfg_wr_en / cfg_index / cfg_wdata; the user
// must write them only while the block is idle, which the block does not
// enforce. Indexes 0..5 are b0, b1, b2, a0, a1, a2, others are dropped.
// fault is set when the result clamps or a0 is zero.
// ----------------------------------------------------------------------------
module biquad_iir_filter #(
    parameter int HISTORY_DEPTH = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  biq_pkg::biq_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output biq_pkg::biq_out_t                  m_data,
    input  logic                               cfg_wr_en,
    input  logic [biq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [biq_pkg::COEF_W-1:0]         cfg_wdata
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);

    function automatic logic [1:0] mod3(input logic [15:0] v);
        logic [4:0] f1;
        logic [3:0] f2;
        logic [2:0] f3;
        f1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6])
           + 5'(v[9:8]) + 5'(v[11:10]) + 5'(v[13:12]) + 5'(v[15:14]);
        f2 = 4'(f1[1:0]) + 4'(f1[3:2]) + 4'(f1[4]);
        f3 = 3'(f2[1:0]) + 3'(f2[3:2]);
        return (f3 >= 3'd3) ? 2'(f3 - 3'd3) : f3[1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] back1(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : SLOT_W'(s - 1'b1);
    endfunction

    logic signed [15:0] b0_reg, b1_reg, b2_reg, a0_reg, a1_reg, a2_reg;
    logic signed [15:0] xh_reg [HISTORY_DEPTH];
    logic signed [15:0] yh_reg [HISTORY_DEPTH];

    logic [SLOT_W-1:0]  slot_reg, s1_reg, s2_reg;
    logic               busy_reg;
    logic [biq_pkg::PC_W-1:0]  pc_reg;
    logic [biq_pkg::CNT_W-1:0] cnt_reg;
    logic signed [biq_pkg::PROD_W-1:0] prod_reg;
    logic signed [biq_pkg::ACC_W-1:0]  acc_reg;
    logic               m_valid_reg;
    biq_pkg::biq_out_t  m_data_reg;

    biq_pkg::biq_ucode_t   cw;
    biq_pkg::biq_div_ctl_t div_ctl;
    logic [SLOT_W-1:0]     in_slot, in_s1;
    logic signed [15:0]    mul_a, mul_b;
    logic signed [biq_pkg::PROD_W-1:0] prod_next;
    logic signed [biq_pkg::ACC_W-1:0]  prod_ext;
    logic [biq_pkg::ACC_W-1:0] acc_neg;
    logic [biq_pkg::MAG_W-1:0] acc_mag, quo;
    logic [15:0]           a0_mag;
    logic                  q_neg, sat_pos, sat_neg, out_free, finish;
    logic signed [15:0]    y_next;
    logic                  fault_next;
    logic                  accept;

    assign accept   = s_valid && !busy_reg;
    assign s_ready  = !busy_reg;
    assign cw       = biq_pkg::biq_ucode(pc_reg);
    assign in_slot  = SLOT_W'(mod3(s_data.sample_count));
    assign in_s1    = back1(in_slot);
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = busy_reg && (cw.seq == biq_pkg::SEQ_DONE) && out_free;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cw.msel)
            biq_pkg::MS_B0X0: begin mul_a = b0_reg; mul_b = xh_reg[slot_reg]; end
            biq_pkg::MS_B1X1: begin mul_a = b1_reg; mul_b = xh_reg[s1_reg]; end
            biq_pkg::MS_B2X2: begin mul_a = b2_reg; mul_b = xh_reg[s2_reg]; end
            biq_pkg::MS_A1Y1: begin mul_a = a1_reg; mul_b = yh_reg[s1_reg]; end
            biq_pkg::MS_A2Y2: begin mul_a = a2_reg; mul_b = yh_reg[s2_reg]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        prod_next = mul_a * mul_b;
    end

    assign prod_ext = {{(biq_pkg::ACC_W - biq_pkg::PROD_W){prod_reg[biq_pkg::PROD_W-1]}},
                       prod_reg};
    assign acc_neg  = biq_pkg::ACC_W'(~acc_reg + 1'b1);
    assign acc_mag  = acc_reg[biq_pkg::ACC_W-1] ? acc_neg[biq_pkg::MAG_W-1:0]
                                                : acc_reg[biq_pkg::MAG_W-1:0];
    assign a0_mag   = a0_reg[15] ? 16'(~a0_reg + 1'b1) : a0_reg;

    assign div_ctl.init = busy_reg && (cw.divop == biq_pkg::DIV_INIT);
    assign div_ctl.step = busy_reg && (cw.divop == biq_pkg::DIV_STEP);

    biq_divider u_div (
        .aclk     (aclk),
        .ctl      (div_ctl),
        .dividend (acc_mag),
        .divisor  (a0_mag),
        .quotient (quo)
    );

    always_comb begin
        q_neg   = acc_reg[biq_pkg::ACC_W-1] ^ a0_reg[15];
        sat_pos = |quo[biq_pkg::MAG_W-1:15];
        sat_neg = (|quo[biq_pkg::MAG_W-1:16]) || (quo[15] && (|quo[14:0]));
        if (a0_reg == '0) begin
            y_next     = acc_reg[biq_pkg::ACC_W-1] ? 16'sh8000 : 16'sh7fff;
            fault_next = 1'b1;
        end else if (!q_neg && sat_pos) begin
            y_next     = 16'sh7fff;
            fault_next = 1'b1;
        end else if (q_neg && sat_neg) begin
            y_next     = 16'sh8000;
            fault_next = 1'b1;
        end else begin
            y_next     = q_neg ? 16'(~quo[15:0] + 1'b1) : quo[15:0];
            fault_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg      <= 16'sd16384;
            b1_reg      <= '0;
            b2_reg      <= '0;
            a0_reg      <= 16'sd16384;
            a1_reg      <= '0;
            a2_reg      <= '0;
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    biq_pkg::REG_B0: b0_reg <= cfg_wdata;
                    biq_pkg::REG_B1: b1_reg <= cfg_wdata;
                    biq_pkg::REG_B2: b2_reg <= cfg_wdata;
                    biq_pkg::REG_A0: a0_reg <= cfg_wdata;
                    biq_pkg::REG_A1: a1_reg <= cfg_wdata;
                    biq_pkg::REG_A2: a2_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && !finish) begin
                m_valid_reg <= 1'b0;
            end

            if (accept) begin
                busy_reg        <= 1'b1;
                pc_reg          <= '0;
                xh_reg[in_slot] <= s_data.sample_in;
            end else if (busy_reg) begin
                case (cw.seq)
                    biq_pkg::SEQ_NEXT: pc_reg <= biq_pkg::PC_W'(pc_reg + 1'b1);
                    biq_pkg::SEQ_LOOP: begin
                        if (cnt_reg == '0) begin
                            pc_reg <= biq_pkg::PC_W'(pc_reg + 1'b1);
                        end
                    end
                    default: begin
                        if (out_free) begin
                            busy_reg         <= 1'b0;
                            m_valid_reg      <= 1'b1;
                            yh_reg[slot_reg] <= y_next;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg <= in_slot;
            s1_reg   <= in_s1;
            s2_reg   <= back1(in_s1);
        end
        if (busy_reg && cw.msel != biq_pkg::MS_NONE) begin
            prod_reg <= prod_next;
        end
        if (busy_reg) begin
            case (cw.accop)
                biq_pkg::ACC_LOAD: acc_reg <= prod_ext;
                biq_pkg::ACC_ADD:  acc_reg <= biq_pkg::ACC_W'(acc_reg + prod_ext);
                biq_pkg::ACC_SUB:  acc_reg <= biq_pkg::ACC_W'(acc_reg - prod_ext);
                default: ;
            endcase
        end
        if (div_ctl.init) begin
            cnt_reg <= biq_pkg::CNT_W'(biq_pkg::DIV_ITERS - 1);
        end else if (div_ctl.step && cnt_reg != '0) begin
            cnt_reg <= biq_pkg::CNT_W'(cnt_reg - 1'b1);
        end
        if (finish) begin
            m_data_reg.sample_out <= y_next;
            m_data_reg.fault      <= fault_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/biq_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad divider
// Unsigned restoring divider, two quotient bits per step, MSB first.
// ----------------------------------------------------------------------------
module biq_divider (
    input  logic                       aclk,
    input  biq_pkg::biq_div_ctl_t      ctl,
    input  logic [biq_pkg::MAG_W-1:0]  dividend,
    input  logic [15:0]                divisor,
    output logic [biq_pkg::MAG_W-1:0]  quotient
);

    logic [biq_pkg::MAG_W-1:0] dq_reg;
    logic [15:0]               rem_reg;
    logic [15:0]               dv_reg;

    logic [16:0] t1, t2;
    logic [15:0] r1, r2;
    logic        b1, b2;

    always_comb begin
        t1 = {rem_reg, dq_reg[biq_pkg::MAG_W-1]};
        b1 = (t1 >= {1'b0, dv_reg});
        r1 = b1 ? 16'(t1 - {1'b0, dv_reg}) : t1[15:0];
        t2 = {r1, dq_reg[biq_pkg::MAG_W-2]};
        b2 = (t2 >= {1'b0, dv_reg});
        r2 = b2 ? 16'(t2 - {1'b0, dv_reg}) : t2[15:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.init) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dv_reg  <= divisor;
        end else if (ctl.step) begin
            dq_reg  <= {dq_reg[biq_pkg::MAG_W-3:0], b1, b2};
            rem_reg <= r2;
        end
    end

    assign quotient = dq_reg;

endmodule

// ===== test/tb_biquad_iir_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad IIR filter testbench
// Drives samples through the valid/ready input channel and predicts each
// filtered output with a local direct form I model that keeps its own input
// and output histories and coefficient set. Every output beat is compared
// with the oldest prediction. Directed checks cover pass-through, truncation
// of the divide, clamping, a zero divisor and dropped register indexes;
// random phases follow with new coefficients each time, idle gaps on both
// channels, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb_biquad_iir_filter;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 130;

    localparam logic [biq_pkg::CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [biq_pkg::CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    typedef enum int {
        COEF_MILD,
        COEF_WILD,
        COEF_CORNER,
        COEF_NO_DIV
    } coef_mode_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    biq_pkg::biq_in_t              s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b1;
    biq_pkg::biq_out_t             m_data;
    logic                          cfg_wr_en = 1'b0;
    logic [biq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [biq_pkg::COEF_W-1:0]    cfg_wdata = '0;

    shortint           coef_tbl [6];
    shortint           x_hist [3];
    shortint           y_hist [3];
    biq_pkg::biq_out_t pending_y_q [$];

    int fail_count  = 0;
    int cycle_count = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    int hold_req    = 0;
    int hold_left   = 0;
    int rx_gap      = 0;

    biquad_iir_filter #(
        .HISTORY_DEPTH(3)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    function automatic shortint pick_corner();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            4: return 16'sh0001;
            default: return 16'sh4000;
        endcase
    endfunction

    function automatic logic [15:0] rand_sample();
        if ($urandom_range(0, 7) == 0) return pick_corner();
        return 16'($urandom);
    endfunction

    function automatic void reset_model();
        coef_tbl[biq_pkg::REG_B0] = 16384;
        coef_tbl[biq_pkg::REG_B1] = 0;
        coef_tbl[biq_pkg::REG_B2] = 0;
        coef_tbl[biq_pkg::REG_A0] = 16384;
        coef_tbl[biq_pkg::REG_A1] = 0;
        coef_tbl[biq_pkg::REG_A2] = 0;
        for (int i = 0; i < 3; i++) begin
            x_hist[i] = 0;
            y_hist[i] = 0;
        end
    endfunction

    function automatic biq_pkg::biq_out_t filter_step(input logic [15:0] x,
                                                      input logic [15:0] cnt);
        int                slot;
        int                s1;
        int                s2;
        longint            acc;
        longint            q;
        shortint           y;
        logic              flt;
        biq_pkg::biq_out_t res;
        slot = int'(cnt) % 3;
        s1   = (slot + 2) % 3;
        s2   = (slot + 1) % 3;
        flt  = 1'b0;
        x_hist[slot] = shortint'(x);
        acc = longint'(coef_tbl[biq_pkg::REG_B0]) * longint'(x_hist[slot])
            + longint'(coef_tbl[biq_pkg::REG_B1]) * longint'(x_hist[s1])
            + longint'(coef_tbl[biq_pkg::REG_B2]) * longint'(x_hist[s2])
            - longint'(coef_tbl[biq_pkg::REG_A1]) * longint'(y_hist[s1])
            - longint'(coef_tbl[biq_pkg::REG_A2]) * longint'(y_hist[s2]);
        if (coef_tbl[biq_pkg::REG_A0] == 0) begin
            y   = (acc < 0) ? -32768 : 32767;
            flt = 1'b1;
        end else begin
            q = acc / longint'(coef_tbl[biq_pkg::REG_A0]);
            if (q > 32767) begin
                y   = 32767;
                flt = 1'b1;
            end else if (q < -32768) begin
                y   = -32768;
                flt = 1'b1;
            end else begin
                y = shortint'(q);
            end
        end
        y_hist[slot]   = y;
        res.sample_out = y;
        res.fault      = flt;
        return res;
    endfunction

    task automatic write_reg(input logic [biq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx <= biq_pkg::REG_A2) coef_tbl[idx] = shortint'(val);
    endtask

    task automatic load_coefs(input shortint b0, input shortint b1, input shortint b2,
                              input shortint a0, input shortint a1, input shortint a2);
        write_reg(biq_pkg::REG_B0, b0);
        write_reg(biq_pkg::REG_B1, b1);
        write_reg(biq_pkg::REG_B2, b2);
        write_reg(biq_pkg::REG_A0, a0);
        write_reg(biq_pkg::REG_A1, a1);
        write_reg(biq_pkg::REG_A2, a2);
    endtask

    task automatic send_sample(input logic [15:0] x, input logic [15:0] cnt);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{sample_in: x, sample_count: cnt};
        do @(posedge aclk); while (!s_ready);
        pending_y_q.push_back(filter_step(x, cnt));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_y_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap--;
        end else begin
            m_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
        end
    end

    always @(posedge aclk) begin
        biq_pkg::biq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_y_q.size() == 0) begin
                $error("output beat with no prediction: sample_out %0d fault %0b",
                       m_data.sample_out, m_data.fault);
                fail_count++;
            end else begin
                want = pending_y_q.pop_front();
                if (m_data.sample_out !== want.sample_out) begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           want.sample_out, m_data.sample_out);
                    fail_count++;
                end
                if (m_data.fault !== want.fault) begin
                    $error("fault mismatch: expected %0b, actual %0b",
                           want.fault, m_data.fault);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_passthrough();
        send_sample(16'sh7FFF, 16'd0);
        send_sample(16'sh8000, 16'd1);
        send_sample(16'sh0000, 16'd2);
        send_sample(16'shFFFF, 16'd3);
        send_sample(16'sh0001, 16'd65535);
        send_sample(16'sh5555, 16'd0);
    endtask

    task automatic test_truncation();
        wait_idle();
        load_coefs(16384, 0, 0, 32767, 0, 0);
        send_sample(16'sd5, 16'd1);
        send_sample(-16'sd5, 16'd2);
        send_sample(16'sh7FFF, 16'd3);
        send_sample(16'sh8000, 16'd4);
    endtask

    task automatic test_saturation();
        wait_idle();
        load_coefs(32767, 32767, 32767, 1, -32768, -32768);
        send_sample(16'sh7FFF, 16'd0);
        send_sample(16'sh7FFF, 16'd1);
        send_sample(16'sh8000, 16'd2);
        send_sample(16'sh8000, 16'd3);
        wait_idle();
        load_coefs(-32768, -32768, -32768, -32768, 32767, 32767);
        send_sample(16'sh7FFF, 16'd4);
        send_sample(16'sh8000, 16'd5);
    endtask

    task automatic test_zero_divisor();
        wait_idle();
        load_coefs(16384, 0, 0, 0, 0, 0);
        send_sample(16'sd100, 16'd0);
        send_sample(-16'sd100, 16'd1);
        send_sample(16'sd0, 16'd2);
    endtask

    task automatic test_spare_index();
        wait_idle();
        load_coefs(16384, 0, 0, 16384, 0, 0);
        write_reg(REG_SPARE6, 16'($urandom));
        write_reg(REG_SPARE7, 16'($urandom));
        send_sample(16'sd1234, 16'd3);
        send_sample(-16'sd4321, 16'd4);
    endtask

    task automatic load_random_coefs(input coef_mode_t mode);
        shortint c [6];
        for (int i = 0; i < 6; i++) begin
            case (mode)
                COEF_MILD:   c[i] = shortint'($urandom_range(0, 16384)) - 8192;
                COEF_CORNER: c[i] = pick_corner();
                default:     c[i] = shortint'($urandom);
            endcase
        end
        if (mode == COEF_MILD) c[biq_pkg::REG_A0] = $urandom_range(0, 1) ? 16384 : -16384;
        if (mode == COEF_NO_DIV) c[biq_pkg::REG_A0] = 0;
        load_coefs(c[biq_pkg::REG_B0], c[biq_pkg::REG_B1], c[biq_pkg::REG_B2],
                   c[biq_pkg::REG_A0], c[biq_pkg::REG_A1], c[biq_pkg::REG_A2]);
    endtask

    task automatic run_stream(input int n_items);
        logic [15:0] cnt;
        cnt = $urandom_range(0, 3) == 0 ? 16'($urandom_range(65500, 65535)) : 16'($urandom);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 7) == 0) cnt = 16'($urandom);
            else cnt = cnt + 16'd1;
            send_sample(rand_sample(), cnt);
        end
    endtask

    task automatic test_random_phases();
        coef_mode_t mode;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 5)
                0, 3:    mode = COEF_MILD;
                1:       mode = COEF_WILD;
                2:       mode = COEF_CORNER;
                default: mode = (p == 4) ? COEF_NO_DIV : COEF_WILD;
            endcase
            wait_idle();
            load_random_coefs(mode);
            run_stream(PHASE_ITEMS);
        end
    endtask

    task automatic test_streaming();
        wait_idle();
        load_random_coefs(COEF_MILD);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_stream(200);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_idle();
        load_random_coefs(COEF_WILD);
        tx_idle_on = 1'b0;
        hold_req   = 400;
        run_stream(40);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        run_stream(30);
        wait_idle();
        run_stream(30);
    endtask

    initial begin
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_truncation();
        test_saturation();
        test_zero_divisor();
        test_spare_index();
        test_random_phases();
        test_streaming();
        test_backpressure();
        test_sender_pause();

        wait_idle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
